// ===== hdl/pmtu_pkg.sv =====
// Types and constants shared by the path-MTU search block.
// No dependencies; every other file in hdl/ uses this package.
`default_nettype none

package pmtu_pkg;

	localparam int SIZE_W = 16;
	localparam int GAP_W  = 12;
	localparam int TIME_W = 48;
	localparam int CIDX_W = 2;

	typedef enum logic [2:0] {
		OP_RESET        = 3'd0,
		OP_ARM_PROBE    = 3'd1,
		OP_PROBE_ACK    = 3'd2,
		OP_PROBE_TMO    = 3'd3,
		OP_PROBE_LOSS   = 3'd4,
		OP_ICMP_FRAG    = 3'd5,
		OP_ICMP_UNKNOWN = 3'd6
	} op_t;

	localparam logic [CIDX_W-1:0] CFG_FLOOR_START = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_DONE_GAP    = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_INTERVAL    = 2'd2;

	localparam logic [SIZE_W-1:0] FLOOR_START_RST = 16'd576;
	localparam logic [GAP_W-1:0]  DONE_GAP_RST    = 12'd16;
	localparam logic [TIME_W-1:0] INTERVAL_RST    = 48'd1800000;

	typedef struct packed {
		logic [SIZE_W-1:0] floor_start;
		logic [GAP_W-1:0]  done_gap;
		logic [TIME_W-1:0] interval;
	} cfg_t;

	typedef struct packed {
		logic [SIZE_W-1:0] floor;
		logic [SIZE_W-1:0] ceiling;
		logic [SIZE_W-1:0] current;
		logic [SIZE_W-1:0] probe_id;
		logic [SIZE_W-1:0] probe_mtu;
		logic [TIME_W-1:0] deadline;
	} search_state_t;

endpackage

`default_nettype wire

// ===== hdl/path_mtu_binary_search.sv =====
// Top level of the path-MTU binary search block: input stage, search state, result register.
// Depends on pmtu_pkg, pmtu_cfg and pmtu_update.
//
// Each event beat is taken into an input register, where the candidate deadline
// (now_ms plus the rediscovery interval) is also formed. When the output side can
// take a result (out_valid low or out_ready high), the update logic reads that register
// and the search state, writes the new state and loads the result register, and one
// event is accepted every cycle while the output side
// keeps taking results.
// The state feedback through the update logic is the loop that sets
// this rate. Configuration is written through cfg_we, cfg_index and cfg_data and
// must only change while no event is in flight.
`default_nettype none

module path_mtu_binary_search (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [pmtu_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [pmtu_pkg::TIME_W-1:0]  cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [2:0]                   operation,
	input  wire logic [pmtu_pkg::SIZE_W-1:0]  seq_number,
	input  wire logic [pmtu_pkg::SIZE_W-1:0]  size_value,
	input  wire logic [pmtu_pkg::SIZE_W-1:0]  packets_in_flight,
	input  wire logic [pmtu_pkg::TIME_W-1:0]  now_ms,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [pmtu_pkg::SIZE_W-1:0]       floor_size,
	output logic [pmtu_pkg::SIZE_W-1:0]       ceiling_size,
	output logic [pmtu_pkg::SIZE_W-1:0]       current_size,
	output logic                              probe_active,
	output logic [pmtu_pkg::SIZE_W-1:0]       probe_seq_out,
	output logic [pmtu_pkg::SIZE_W-1:0]       probe_size_out,
	output logic                              matched,
	output logic                              search_done,
	output logic                              rediscover_due
);

	localparam int SW = pmtu_pkg::SIZE_W;
	localparam int TW = pmtu_pkg::TIME_W;

	pmtu_pkg::cfg_t          cfg;
	pmtu_pkg::search_state_t state_q;
	pmtu_pkg::search_state_t state_nxt;
	logic                    matched_nxt;

	logic          valid_s1;
	logic [2:0]    op_s1;
	logic [SW-1:0] seq_s1;
	logic [SW-1:0] size_s1;
	logic [SW-1:0] inflight_s1;
	logic [TW-1:0] now_s1;
	logic [TW-1:0] deadline_s1;
	logic          advance;

	pmtu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1       <= operation;
			seq_s1      <= seq_number;
			size_s1     <= size_value;
			inflight_s1 <= packets_in_flight;
			now_s1      <= now_ms;
			deadline_s1 <= now_ms + cfg.interval;
		end
	end

	pmtu_update u_update (
		.st                (state_q),
		.operation         (op_s1),
		.seq_number        (seq_s1),
		.size_value        (size_s1),
		.packets_in_flight (inflight_s1),
		.deadline_cand     (deadline_s1),
		.floor_start       (cfg.floor_start),
		.done_gap          (cfg.done_gap),
		.nxt               (state_nxt),
		.matched           (matched_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			floor_size     <= state_nxt.floor;
			ceiling_size   <= state_nxt.ceiling;
			current_size   <= state_nxt.current;
			probe_active   <= (state_nxt.probe_id != '0);
			probe_seq_out  <= state_nxt.probe_id;
			probe_size_out <= state_nxt.probe_mtu;
			matched        <= matched_nxt;
			search_done    <= (state_nxt.floor == state_nxt.ceiling);
			rediscover_due <= (now_s1 >= state_nxt.deadline);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pmtu_cfg.sv =====
// Configuration registers of the path-MTU search block.
// Depends on pmtu_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module pmtu_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [pmtu_pkg::CIDX_W-1:0]  cfg_index,
	input  wire logic [pmtu_pkg::TIME_W-1:0]  cfg_data,
	output pmtu_pkg::cfg_t                    cfg
);

	pmtu_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.floor_start <= pmtu_pkg::FLOOR_START_RST;
			cfg_q.done_gap    <= pmtu_pkg::DONE_GAP_RST;
			cfg_q.interval    <= pmtu_pkg::INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pmtu_pkg::CFG_FLOOR_START: cfg_q.floor_start <= cfg_data[pmtu_pkg::SIZE_W-1:0];
				pmtu_pkg::CFG_DONE_GAP:    cfg_q.done_gap    <= cfg_data[pmtu_pkg::GAP_W-1:0];
				pmtu_pkg::CFG_INTERVAL:    cfg_q.interval    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/pmtu_update.sv =====
// Next-state logic of the search window for one event beat.
// Depends on pmtu_pkg for op_t and search_state_t; purely combinational.
`default_nettype none

module pmtu_update (
	input  wire pmtu_pkg::search_state_t      st,
	input  wire logic [2:0]                   operation,
	input  wire logic [pmtu_pkg::SIZE_W-1:0]  seq_number,
	input  wire logic [pmtu_pkg::SIZE_W-1:0]  size_value,
	input  wire logic [pmtu_pkg::SIZE_W-1:0]  packets_in_flight,
	input  wire logic [pmtu_pkg::TIME_W-1:0]  deadline_cand,
	input  wire logic [pmtu_pkg::SIZE_W-1:0]  floor_start,
	input  wire logic [pmtu_pkg::GAP_W-1:0]   done_gap,
	output pmtu_pkg::search_state_t           nxt,
	output logic                              matched
);

	localparam int SW = pmtu_pkg::SIZE_W;

	function automatic logic [SW-1:0] clamp_ceil(input logic [SW-1:0] c, input logic [SW-1:0] f);
		return (c < f) ? f : c;
	endfunction

	pmtu_pkg::search_state_t pre;
	logic                    do_bisect;
	logic                    frag;
	logic                    hit;
	logic [SW-1:0]           lowered;
	logic [SW-1:0]           frag_min;
	logic [SW:0]             old_sum;
	logic [SW:0]             new_sum;
	logic [SW:0]             gap;
	logic                    close;

	assign hit      = (st.probe_id != '0) && (seq_number == st.probe_id);
	assign lowered  = (st.probe_mtu == '0) ? st.floor
	                                       : clamp_ceil(st.probe_mtu - SW'(1), st.floor);
	assign frag_min = (size_value < st.ceiling) ? size_value : st.ceiling;
	assign old_sum  = {1'b0, st.floor} + {1'b0, st.ceiling};

	always_comb begin
		pre       = st;
		do_bisect = 1'b0;
		frag      = 1'b0;
		matched   = 1'b0;
		case (pmtu_pkg::op_t'(operation))
			pmtu_pkg::OP_RESET: begin
				pre.floor    = floor_start;
				pre.ceiling  = clamp_ceil(size_value, floor_start);
				pre.deadline = deadline_cand;
			end
			pmtu_pkg::OP_ARM_PROBE: begin
				pre.probe_id  = seq_number;
				pre.probe_mtu = size_value;
			end
			pmtu_pkg::OP_PROBE_ACK: begin
				if (hit) begin
					pre.floor   = st.probe_mtu;
					pre.ceiling = clamp_ceil(st.ceiling, st.probe_mtu);
					do_bisect   = 1'b1;
					matched     = 1'b1;
				end
			end
			pmtu_pkg::OP_PROBE_TMO: begin
				if (hit && packets_in_flight == SW'(1)) begin
					pre.ceiling = lowered;
					do_bisect   = 1'b1;
					matched     = 1'b1;
				end
				pre.probe_id  = '0;
				pre.probe_mtu = '0;
			end
			pmtu_pkg::OP_PROBE_LOSS: begin
				pre.ceiling = lowered;
				do_bisect   = 1'b1;
			end
			pmtu_pkg::OP_ICMP_FRAG: begin
				pre.ceiling = clamp_ceil(frag_min, st.floor);
				do_bisect   = 1'b1;
				frag        = 1'b1;
			end
			pmtu_pkg::OP_ICMP_UNKNOWN: begin
				pre.ceiling = clamp_ceil(old_sum[SW:1], st.floor);
				do_bisect   = 1'b1;
			end
			default: ;
		endcase
	end

	assign new_sum = {1'b0, pre.floor} + {1'b0, pre.ceiling};
	assign gap     = {1'b0, pre.ceiling} - {1'b0, pre.floor};
	assign close   = !gap[SW] && (gap[SW-1:0] <= {{(SW-pmtu_pkg::GAP_W){1'b0}}, done_gap});

	always_comb begin
		nxt = pre;
		if (do_bisect) begin
			nxt.current   = new_sum[SW:1];
			nxt.probe_id  = '0;
			nxt.probe_mtu = '0;
			if (close) begin
				nxt.current  = pre.floor;
				nxt.ceiling  = pre.floor;
				nxt.deadline = deadline_cand;
			end
			if (frag) begin
				nxt.current = close ? pre.floor : pre.ceiling;
			end
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_path_mtu_binary_search.sv =====
// Self-checking bench for path_mtu_binary_search: valid/ready event and result channels.
// Needs pmtu_pkg and the block's RTL only; a local search-window model predicts each result.
`timescale 1ns / 1ps

module tb_path_mtu_binary_search;

	localparam int SIZE_W = pmtu_pkg::SIZE_W;
	localparam int TIME_W = pmtu_pkg::TIME_W;
	localparam int GAP_W  = pmtu_pkg::GAP_W;
	localparam int CIDX_W = pmtu_pkg::CIDX_W;

	localparam logic [2:0] OP_UNDEFINED = 3'd7;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int CYCLE_LIMIT     = 400000;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct {
		logic [2:0]        op;
		logic [SIZE_W-1:0] seq;
		logic [SIZE_W-1:0] size;
		logic [SIZE_W-1:0] inflight;
		logic [TIME_W-1:0] now;
	} event_t;

	typedef struct {
		logic [SIZE_W-1:0] floor;
		logic [SIZE_W-1:0] ceiling;
		logic [SIZE_W-1:0] current;
		logic              active;
		logic [SIZE_W-1:0] pseq;
		logic [SIZE_W-1:0] psize;
		logic              matched;
		logic              done;
		logic              due;
	} window_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [TIME_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] operation = '0;
	logic [SIZE_W-1:0] seq_number = '0;
	logic [SIZE_W-1:0] size_value = '0;
	logic [SIZE_W-1:0] packets_in_flight = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [SIZE_W-1:0] floor_size;
	logic [SIZE_W-1:0] ceiling_size;
	logic [SIZE_W-1:0] current_size;
	logic probe_active;
	logic [SIZE_W-1:0] probe_seq_out;
	logic [SIZE_W-1:0] probe_size_out;
	logic matched;
	logic search_done;
	logic rediscover_due;

	pmtu_pkg::cfg_t cfg = '{pmtu_pkg::FLOOR_START_RST, pmtu_pkg::DONE_GAP_RST,
		pmtu_pkg::INTERVAL_RST};
	pmtu_pkg::search_state_t st = '0;
	event_t        event_q[$];
	window_t       window_q[$];
	event_t        live_event;
	int            mismatches = 0;
	int            cycle_count = 0;
	int            send_gap = 0;
	int            recv_stall = 0;
	logic          send_idle = 1'b1;
	logic          recv_idle = 1'b1;

	path_mtu_binary_search i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.seq_number(seq_number),
		.size_value(size_value),
		.packets_in_flight(packets_in_flight),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.floor_size(floor_size),
		.ceiling_size(ceiling_size),
		.current_size(current_size),
		.probe_active(probe_active),
		.probe_seq_out(probe_seq_out),
		.probe_size_out(probe_size_out),
		.matched(matched),
		.search_done(search_done),
		.rediscover_due(rediscover_due)
	);

	always #5 clk = ~clk;

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] bits;
		bits = {$urandom(), $urandom()};
		return bits[TIME_W-1:0];
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void set_ceiling(logic [SIZE_W-1:0] c);
		st.ceiling = (c < st.floor) ? st.floor : c;
	endfunction

	function automatic void lower_to_probe();
		if (st.probe_mtu == '0)
			set_ceiling(st.floor);
		else
			set_ceiling(st.probe_mtu - 1'b1);
	endfunction

	function automatic logic [SIZE_W-1:0] midpoint();
		logic [SIZE_W:0] total;
		total = {1'b0, st.floor} + {1'b0, st.ceiling};
		return total[SIZE_W:1];
	endfunction

	function automatic void rebisect(logic [TIME_W-1:0] now);
		st.current = midpoint();
		st.probe_id = '0;
		st.probe_mtu = '0;
		if (st.ceiling >= st.floor && st.ceiling - st.floor <= {4'b0, cfg.done_gap}) begin
			st.current = st.floor;
			st.ceiling = st.floor;
			st.deadline = now + cfg.interval;
		end
	endfunction

	function automatic window_t next_window(event_t e);
		window_t w;
		logic    hit;
		hit = (st.probe_id != '0) && (e.seq == st.probe_id);
		w.matched = 1'b0;
		case (e.op)
			pmtu_pkg::OP_RESET: begin
				st.floor = cfg.floor_start;
				set_ceiling(e.size);
				st.deadline = e.now + cfg.interval;
			end
			pmtu_pkg::OP_ARM_PROBE: begin
				st.probe_id = e.seq;
				st.probe_mtu = e.size;
			end
			pmtu_pkg::OP_PROBE_ACK: begin
				if (hit) begin
					st.floor = st.probe_mtu;
					if (st.ceiling < st.floor)
						st.ceiling = st.floor;
					rebisect(e.now);
					w.matched = 1'b1;
				end
			end
			pmtu_pkg::OP_PROBE_TMO: begin
				if (e.inflight == 16'd1 && hit) begin
					lower_to_probe();
					rebisect(e.now);
					w.matched = 1'b1;
				end
				st.probe_id = '0;
				st.probe_mtu = '0;
			end
			pmtu_pkg::OP_PROBE_LOSS: begin
				lower_to_probe();
				rebisect(e.now);
			end
			pmtu_pkg::OP_ICMP_FRAG: begin
				set_ceiling((e.size < st.ceiling) ? e.size : st.ceiling);
				rebisect(e.now);
				st.current = st.ceiling;
			end
			pmtu_pkg::OP_ICMP_UNKNOWN: begin
				set_ceiling(midpoint());
				rebisect(e.now);
			end
			default: begin
			end
		endcase
		w.floor = st.floor;
		w.ceiling = st.ceiling;
		w.current = st.current;
		w.active = (st.probe_id != '0);
		w.pseq = st.probe_id;
		w.psize = st.probe_mtu;
		w.done = (st.floor == st.ceiling);
		w.due = (e.now >= st.deadline);
		return w;
	endfunction

	task automatic push_event(logic [2:0] op, logic [SIZE_W-1:0] seq, logic [SIZE_W-1:0] size,
			logic [SIZE_W-1:0] inflight, logic [TIME_W-1:0] now);
		event_t e;
		e.op = op;
		e.seq = seq;
		e.size = size;
		e.inflight = inflight;
		e.now = now;
		event_q = {event_q, e};
	endtask

	task automatic write_reg(logic [CIDX_W-1:0] idx, logic [TIME_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			pmtu_pkg::CFG_FLOOR_START: cfg.floor_start = data[SIZE_W-1:0];
			pmtu_pkg::CFG_DONE_GAP:    cfg.done_gap = data[GAP_W-1:0];
			pmtu_pkg::CFG_INTERVAL:    cfg.interval = data;
			default: begin
			end
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (event_q.size() != 0 || in_valid || window_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic note_mismatch(string what, logic [SIZE_W-1:0] got, logic [SIZE_W-1:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic compare_field(string what, logic [SIZE_W-1:0] got, logic [SIZE_W-1:0] want);
		if (got !== want)
			note_mismatch(what, got, want);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("path_mtu_binary_search test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				window_q = {window_q, next_window(live_event)};
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (event_q.size() > 0) begin
					live_event = event_q.pop_front();
					operation <= live_event.op;
					seq_number <= live_event.seq;
					size_value <= live_event.size;
					packets_in_flight <= live_event.inflight;
					now_ms <= live_event.now;
					in_valid <= 1'b1;
					send_gap = send_idle ? pick_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		window_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (window_q.size() == 0) begin
					note_mismatch("unexpected result beat", 16'd1, 16'd0);
				end else begin
					want = window_q.pop_front();
					compare_field("floor_size", floor_size, want.floor);
					compare_field("ceiling_size", ceiling_size, want.ceiling);
					compare_field("current_size", current_size, want.current);
					compare_field("probe_active", 16'(probe_active), 16'(want.active));
					compare_field("probe_seq_out", probe_seq_out, want.pseq);
					compare_field("probe_size_out", probe_size_out, want.psize);
					compare_field("matched", 16'(matched), 16'(want.matched));
					compare_field("search_done", 16'(search_done), 16'(want.done));
					compare_field("rediscover_due", 16'(rediscover_due), 16'(want.due));
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (recv_idle && $urandom_range(0, 99) < 20)
					recv_stall = pick_gap();
			end
		end
	end

	initial begin
		int                pick;
		logic [SIZE_W-1:0] lo;
		logic [SIZE_W-1:0] hi;
		logic [SIZE_W-1:0] probe_sz;
		logic [SIZE_W-1:0] link_mtu;
		logic [SIZE_W-1:0] armed_seq;
		logic              armed;
		logic [TIME_W-1:0] now_cursor;
		logic [SIZE_W-1:0] floor_val;
		logic [GAP_W-1:0]  gap_val;
		logic [TIME_W-1:0] interval_val;

		armed = 1'b0;
		armed_seq = '0;
		now_cursor = 48'd5000;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed events under the reset configuration.
		push_event(pmtu_pkg::OP_RESET, 16'd0, 16'd1500, 16'd0, 48'd1000);
		push_event(pmtu_pkg::OP_ARM_PROBE, 16'd1, 16'd1038, 16'd0, 48'd1500);
		push_event(pmtu_pkg::OP_PROBE_ACK, 16'd1, 16'd0, 16'd0, 48'd2000);
		push_event(pmtu_pkg::OP_ARM_PROBE, 16'd2, 16'd1269, 16'd0, 48'd2100);
		push_event(pmtu_pkg::OP_PROBE_ACK, 16'd3, 16'd0, 16'd0, 48'd2200);
		push_event(pmtu_pkg::OP_PROBE_TMO, 16'd2, 16'd0, 16'd2, 48'd2300);
		push_event(pmtu_pkg::OP_ARM_PROBE, 16'd4, 16'd1269, 16'd0, 48'd2400);
		push_event(pmtu_pkg::OP_PROBE_TMO, 16'd4, 16'd0, 16'd1, 48'd2500);
		push_event(pmtu_pkg::OP_PROBE_TMO, 16'd4, 16'd0, 16'd1, 48'd2600);
		push_event(pmtu_pkg::OP_ARM_PROBE, 16'd0, 16'd1200, 16'd0, 48'd2700);
		push_event(pmtu_pkg::OP_PROBE_ACK, 16'd0, 16'd0, 16'd0, 48'd2800);
		push_event(pmtu_pkg::OP_ARM_PROBE, 16'hFFFF, 16'hFFFF, 16'd0, 48'd2900);
		push_event(pmtu_pkg::OP_PROBE_LOSS, 16'd0, 16'd0, 16'd0, 48'd3000);
		push_event(pmtu_pkg::OP_ICMP_UNKNOWN, 16'd0, 16'd0, 16'd0, 48'd3100);
		push_event(pmtu_pkg::OP_ICMP_FRAG, 16'd0, 16'd0, 16'd0, 48'd3200);
		push_event(pmtu_pkg::OP_PROBE_LOSS, 16'd0, 16'd0, 16'd0, 48'd3300);
		push_event(pmtu_pkg::OP_RESET, 16'd0, 16'd0, 16'd0, TIME_MAX);
		push_event(pmtu_pkg::OP_RESET, 16'hFFFF, 16'hFFFF, 16'hFFFF, TIME_MAX);
		push_event(pmtu_pkg::OP_ICMP_FRAG, 16'hFFFF, 16'd9000, 16'hFFFF, 48'd0);
		push_event(pmtu_pkg::OP_ARM_PROBE, 16'd7, 16'd0, 16'd0, 48'd10);
		push_event(pmtu_pkg::OP_PROBE_LOSS, 16'd7, 16'd0, 16'd0, 48'd20);
		push_event(pmtu_pkg::OP_RESET, 16'd0, 16'd1500, 16'd0, 48'd30);
		push_event(pmtu_pkg::OP_ARM_PROBE, 16'd8, 16'd500, 16'd0, 48'd40);
		push_event(pmtu_pkg::OP_PROBE_TMO, 16'd8, 16'd0, 16'd1, 48'd50);
		push_event(OP_UNDEFINED, 16'hFFFF, 16'hFFFF, 16'hFFFF, TIME_MAX);
		wait_drained();

		for (int phase = 1; phase <= PHASES; phase++) begin
			floor_val = (phase == 1) ? 16'd68 :
				(phase == 2) ? 16'hFFFF : 16'($urandom_range(68, 1400));
			gap_val = (phase == 3) ? 12'd0 :
				(phase == 4) ? 12'hFFF : 12'($urandom_range(0, 64));
			interval_val = (phase == 5) ? 48'd0 : (phase == 6) ? TIME_MAX :
				(phase == 7) ? rand48() : 48'($urandom_range(0, 200000));
			write_reg(pmtu_pkg::CFG_FLOOR_START, 48'(floor_val));
			write_reg(pmtu_pkg::CFG_DONE_GAP, 48'(gap_val));
			write_reg(pmtu_pkg::CFG_INTERVAL, interval_val);
			send_idle = (phase == 2) ? 1'b0 : ($urandom_range(0, 99) < 70);
			recv_idle = (phase == 2) ? 1'b0 : ($urandom_range(0, 99) < 70);
			armed = 1'b0;
			push_event(pmtu_pkg::OP_RESET, 16'd0, 16'($urandom_range(576, 9000)), 16'd0,
				now_cursor);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				while (event_q.size() >= 2)
					@(negedge clk);
				pick = $urandom_range(0, 99);
				if (pick < 5)
					now_cursor = rand48();
				else if (pick < 15)
					now_cursor = st.deadline + 48'($urandom_range(0, 2)) - 48'd1;
				else
					now_cursor = now_cursor + 48'($urandom_range(0, 3000));
				lo = st.floor;
				hi = st.ceiling;
				probe_sz = (hi > lo) ? 16'($urandom_range(int'(lo) + 1, int'(hi))) : lo;
				link_mtu = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(576, 9000)) :
					16'($urandom);
				pick = $urandom_range(0, 99);
				if (pick < 8) begin
					push_event(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
						16'($urandom), rand48());
					armed = 1'b0;
				end else if (st.floor == st.ceiling || pick < 12) begin
					push_event(pmtu_pkg::OP_RESET, 16'($urandom), link_mtu, 16'($urandom),
						now_cursor);
					armed = 1'b0;
				end else if (!armed) begin
					armed_seq = (pick < 16) ? 16'd0 : 16'($urandom_range(1, 65535));
					push_event(pmtu_pkg::OP_ARM_PROBE, armed_seq, probe_sz, 16'($urandom),
						now_cursor);
					armed = 1'b1;
				end else begin
					armed = 1'b0;
					if (pick < 50) begin
						push_event(pmtu_pkg::OP_PROBE_ACK, armed_seq, 16'($urandom),
							16'($urandom), now_cursor);
					end else if (pick < 62) begin
						push_event(pmtu_pkg::OP_PROBE_TMO, armed_seq, 16'($urandom), 16'd1,
							now_cursor);
					end else if (pick < 68) begin
						push_event(pmtu_pkg::OP_PROBE_TMO, armed_seq, 16'($urandom),
							16'($urandom), now_cursor);
					end else if (pick < 76) begin
						push_event(pmtu_pkg::OP_PROBE_ACK, armed_seq + 16'd1, 16'($urandom),
							16'($urandom), now_cursor);
						armed = 1'b1;
					end else if (pick < 84) begin
						push_event(pmtu_pkg::OP_PROBE_LOSS, 16'($urandom), 16'($urandom),
							16'($urandom), now_cursor);
					end else if (pick < 93) begin
						push_event(pmtu_pkg::OP_ICMP_FRAG, 16'($urandom), probe_sz,
							16'($urandom), now_cursor);
					end else begin
						push_event(pmtu_pkg::OP_ICMP_UNKNOWN, 16'($urandom), 16'($urandom),
							16'($urandom), now_cursor);
					end
				end
			end
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("path_mtu_binary_search test passed");
		else
			$display("path_mtu_binary_search test failed");
		$finish;
	end

endmodule
